>>> rtl/imuca_pkg.sv
package imuca_pkg;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SC_MUL,
		ST_SC_WB,
		ST_IN_MUL,
		ST_IN_PREP,
		ST_IN_DIV,
		ST_IN_EST,
		ST_IN_BACK,
		ST_IN_WB,
		ST_SQ0,
		ST_SQ1,
		ST_SQ2,
		ST_SQRT,
		ST_AT_INIT,
		ST_AT_NORM,
		ST_AT_ITER,
		ST_AT_END,
		ST_BL_P,
		ST_BL_M0,
		ST_BL_M1,
		ST_BL_WB,
		ST_YAW,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		REG_ACC_GAIN,
		REG_RATE_GAIN,
		REG_GYRO_BIAS_X,
		REG_GYRO_BIAS_Y,
		REG_GYRO_BIAS_Z,
		REG_DEFAULT_PERIOD,
		REG_INITIAL_ROLL,
		REG_INITIAL_PITCH
	} reg_idx_t;

	localparam logic [31:0] DT_LIMIT_US = 32'd100000;
	localparam logic [49:0] HALF_MEGA = 50'd500000;
	localparam logic [49:0] MEGA_REM = 50'd1000000;
	// floor(2^51 / 10^6): applied to the dividend shifted down by 18, quotient at bit 33
	localparam logic signed [32:0] RECIP_MEGA = 33'sd2251799813;
	localparam logic signed [32:0] MEGA = 33'sd1000000;
	localparam logic [4:0] SQRT_LAST = 5'd31;
	localparam logic [4:0] CORDIC_LAST = 5'd30;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [45:0] NORM_LIMIT = 46'sd1099511627776;
	localparam logic signed [32:0] ALPHA_Q16 = 33'sd64225;
	localparam logic signed [32:0] BETA_Q16 = 33'sd1311;

	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0: r = 30'd843314857;
			5'd1: r = 30'd497837829;
			5'd2: r = 30'd263043837;
			5'd3: r = 30'd133525159;
			5'd4: r = 30'd67021687;
			5'd5: r = 30'd33543516;
			5'd6: r = 30'd16775851;
			5'd7: r = 30'd8388437;
			5'd8: r = 30'd4194283;
			5'd9: r = 30'd2097149;
			default: r = 30'd1 << (5'd30 - i);
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -66'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/imu_complementary_attitude.sv
// channel  dir  signals                     contents
// s        in   s_tvalid/s_tready/s_tdata   one raw six-axis sample, timestamp, restart
// m        out  m_tvalid/m_tready/m_tdata   scaled accel, roll, pitch, yaw
// apb      in   psel/penable/pwrite/paddr   eight configuration registers
// An item holds the block from accept to the next s_tready: six multiplier passes for
// scaling, three integrations (reciprocal multiply by 1/10^6 and one correction), a square
// root and two CORDIC passes with up to 40 normalising shifts each (skipped for a zero
// vector), all on one datapath.
// s_tready is high only while idle. A finished beat waits in the output register while the
// next item runs; the sequencer holds in its last state until that register is free.
// Reset loads the register defaults and clears timestamp and attitude.
module imu_complementary_attitude (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// accel_x_raw, accel_y_raw, accel_z_raw, rate_x_raw, rate_y_raw, rate_z_raw,
	// sample_time_us
	input  logic [127:0] s_tdata,
	// restart
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// accel_x, accel_y, accel_z, roll, pitch, yaw
	output logic [191:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import imuca_pkg::*;

	state_t state_q, state_d;

	logic [31:0] acc_gain_q, rate_gain_q;
	logic signed [31:0] bias_q [3];
	logic [16:0] def_period_q;
	logic [18:0] init_roll_q, init_pitch_q;

	logic [31:0] last_time_q;
	logic signed [31:0] roll_q, pitch_q, yaw_q;

	logic signed [15:0] raw_q [6];
	logic [16:0] dt_q;
	logic [2:0] idx_q;
	logic [4:0] step_q;
	logic which_q;
	logic signed [31:0] acc_q [3];
	logic signed [31:0] gyro_q [3];
	logic signed [29:0] inc_q [3];
	logic signed [65:0] prod_q, sum_q;
	logic signed [32:0] mul_a, mul_b;
	logic neg_q;
	logic [49:0] rem_q;
	logic [28:0] quo_q;
	logic [63:0] sq_q, res_q, bit_q;
	logic [31:0] sqrt_q;
	logic signed [45:0] cx_q, cy_q;
	logic signed [33:0] z_q;
	logic signed [19:0] ang_q [2];
	logic signed [31:0] p_q;
	logic [191:0] out_q;
	logic out_valid_q;

	logic wr_en;
	logic accept;
	logic [31:0] d_raw;
	logic use_def;
	logic signed [31:0] sc_val;
	logic signed [31:0] gy_val;
	logic [65:0] mag;
	logic [49:0] div_rem;
	logic [29:0] quo_fix;
	logic [63:0] sq_try;
	logic signed [33:0] at_x, at_y;
	logic signed [45:0] cy_abs;
	logic signed [45:0] sh_x, sh_y;
	logic signed [34:0] z_rnd;
	logic signed [31:0] st_sel;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid & s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_ACC_GAIN:       prdata = acc_gain_q;
			REG_RATE_GAIN:      prdata = rate_gain_q;
			REG_GYRO_BIAS_X:    prdata = bias_q[0];
			REG_GYRO_BIAS_Y:    prdata = bias_q[1];
			REG_GYRO_BIAS_Z:    prdata = bias_q[2];
			REG_DEFAULT_PERIOD: prdata = {15'd0, def_period_q};
			REG_INITIAL_ROLL:   prdata = {13'd0, init_roll_q};
			REG_INITIAL_PITCH:  prdata = {13'd0, init_pitch_q};
			default:            prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_gain_q <= 32'd2012;
			rate_gain_q <= 32'd571950;
			bias_q[0] <= 32'sd0;
			bias_q[1] <= 32'sd0;
			bias_q[2] <= 32'sd0;
			def_period_q <= 17'd10000;
			init_roll_q <= 19'd0;
			init_pitch_q <= 19'd0;
		end else if (wr_en) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_ACC_GAIN:       acc_gain_q <= pwdata;
				REG_RATE_GAIN:      rate_gain_q <= pwdata;
				REG_GYRO_BIAS_X:    bias_q[0] <= pwdata;
				REG_GYRO_BIAS_Y:    bias_q[1] <= pwdata;
				REG_GYRO_BIAS_Z:    bias_q[2] <= pwdata;
				REG_DEFAULT_PERIOD: def_period_q <= pwdata[16:0];
				REG_INITIAL_ROLL:   init_roll_q <= pwdata[18:0];
				REG_INITIAL_PITCH:  init_pitch_q <= pwdata[18:0];
				default: ;
			endcase
		end
	end

	assign d_raw = s_tdata[127:96] - last_time_q;
	assign use_def = s_tuser[0] | (d_raw == 32'd0) | (d_raw > DT_LIMIT_US);

	// datapath helpers
	assign sc_val = sat32((prod_q + 66'sd32768) >>> 16);
	always_comb begin
		case (idx_q)
			3'd3:    gy_val = sat32(66'(sc_val) - 66'(bias_q[0]));
			3'd4:    gy_val = sat32(66'(sc_val) - 66'(bias_q[1]));
			default: gy_val = sat32(66'(sc_val) - 66'(bias_q[2]));
		endcase
	end
	assign mag = prod_q[65] ? 66'(-prod_q) : 66'(prod_q);
	// the estimate is at most one short; bump it when the remainder still holds 10^6
	assign div_rem = rem_q - prod_q[49:0];
	assign quo_fix = {1'b0, quo_q} + {29'd0, (div_rem >= MEGA_REM)};
	assign sq_try = res_q + bit_q;
	assign at_y = which_q ? -34'(acc_q[0]) : 34'(acc_q[1]);
	assign at_x = which_q ? {2'b00, sqrt_q} : 34'(acc_q[2]);
	assign cy_abs = cy_q[45] ? -cy_q : cy_q;
	assign sh_x = cx_q >>> step_q;
	assign sh_y = cy_q >>> step_q;
	assign z_rnd = 35'(z_q) + 35'sd8192;
	assign st_sel = which_q ? pitch_q : roll_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a = 33'sd0;
		mul_b = 33'sd0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_SC_MUL;
			end
			ST_SC_MUL: begin
				mul_a = 33'(raw_q[idx_q]);
				mul_b = (idx_q < 3'd3) ? {1'b0, acc_gain_q} : {1'b0, rate_gain_q};
				state_d = ST_SC_WB;
			end
			ST_SC_WB: state_d = (idx_q == 3'd5) ? ST_IN_MUL : ST_SC_MUL;
			ST_IN_MUL: begin
				mul_a = 33'(gyro_q[idx_q[1:0]]);
				mul_b = {16'd0, dt_q};
				state_d = ST_IN_PREP;
			end
			ST_IN_PREP: state_d = ST_IN_DIV;
			ST_IN_DIV: begin
				mul_a = {1'b0, rem_q[49:18]};
				mul_b = RECIP_MEGA;
				state_d = ST_IN_EST;
			end
			ST_IN_EST: state_d = ST_IN_BACK;
			ST_IN_BACK: begin
				mul_a = {4'd0, quo_q};
				mul_b = MEGA;
				state_d = ST_IN_WB;
			end
			ST_IN_WB: state_d = (idx_q == 3'd2) ? ST_SQ0 : ST_IN_MUL;
			ST_SQ0: begin
				mul_a = 33'(acc_q[1]);
				mul_b = 33'(acc_q[1]);
				state_d = ST_SQ1;
			end
			ST_SQ1: begin
				mul_a = 33'(acc_q[2]);
				mul_b = 33'(acc_q[2]);
				state_d = ST_SQ2;
			end
			ST_SQ2: state_d = ST_SQRT;
			ST_SQRT: if (step_q == SQRT_LAST) state_d = ST_AT_INIT;
			ST_AT_INIT: state_d = (at_x == 34'sd0 && at_y == 34'sd0) ? ST_AT_END : ST_AT_NORM;
			ST_AT_NORM: begin
				if (!(cx_q < NORM_LIMIT && cy_abs < NORM_LIMIT)) state_d = ST_AT_ITER;
			end
			ST_AT_ITER: if (step_q == CORDIC_LAST) state_d = ST_AT_END;
			ST_AT_END: state_d = which_q ? ST_BL_P : ST_AT_INIT;
			ST_BL_P: state_d = ST_BL_M0;
			ST_BL_M0: begin
				mul_a = 33'(p_q);
				mul_b = ALPHA_Q16;
				state_d = ST_BL_M1;
			end
			ST_BL_M1: begin
				mul_a = 33'(ang_q[which_q]);
				mul_b = BETA_Q16;
				state_d = ST_BL_WB;
			end
			ST_BL_WB: state_d = which_q ? ST_YAW : ST_BL_P;
			ST_YAW: state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// attitude state, timestamp and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= 32'd0;
			roll_q <= 32'sd0;
			pitch_q <= 32'sd0;
			yaw_q <= 32'sd0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				last_time_q <= s_tdata[127:96];
				if (s_tuser[0]) begin
					roll_q <= {{13{init_roll_q[18]}}, init_roll_q};
					pitch_q <= {{13{init_pitch_q[18]}}, init_pitch_q};
					yaw_q <= 32'sd0;
				end
			end
			if (state_q == ST_BL_WB) begin
				if (which_q) pitch_q <= sat32((sum_q + prod_q + 66'sd32768) >>> 16);
				else roll_q <= sat32((sum_q + prod_q + 66'sd32768) >>> 16);
			end
			if (state_q == ST_YAW) yaw_q <= sat32(66'(yaw_q) + 66'(inc_q[2]));
			if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sequencer counters and working registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					raw_q[0] <= s_tdata[15:0];
					raw_q[1] <= s_tdata[31:16];
					raw_q[2] <= s_tdata[47:32];
					raw_q[3] <= s_tdata[63:48];
					raw_q[4] <= s_tdata[79:64];
					raw_q[5] <= s_tdata[95:80];
					dt_q <= use_def ? def_period_q : d_raw[16:0];
					idx_q <= 3'd0;
					which_q <= 1'b0;
				end
			end
			ST_SC_WB: begin
				if (idx_q < 3'd3) acc_q[idx_q[1:0]] <= sc_val;
				else gyro_q[2'(idx_q - 3'd3)] <= gy_val;
				idx_q <= (idx_q == 3'd5) ? 3'd0 : idx_q + 3'd1;
			end
			ST_IN_PREP: begin
				neg_q <= prod_q[65];
				rem_q <= mag[49:0] + HALF_MEGA;
			end
			ST_IN_EST: quo_q <= prod_q[61:33];
			ST_IN_WB: begin
				inc_q[idx_q[1:0]] <= neg_q ? -$signed(quo_fix) : $signed(quo_fix);
				idx_q <= (idx_q == 3'd2) ? 3'd0 : idx_q + 3'd1;
			end
			ST_SQ1: sq_q <= prod_q[63:0];
			ST_SQ2: begin
				sq_q <= sq_q + prod_q[63:0];
				res_q <= 64'd0;
				bit_q <= 64'd1 << 62;
				step_q <= 5'd0;
			end
			ST_SQRT: begin
				if (sq_q >= sq_try) begin
					sq_q <= sq_q - sq_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				step_q <= step_q + 5'd1;
				if (step_q == SQRT_LAST) begin
					if (sq_q >= sq_try) sqrt_q <= 32'((res_q >> 1) + bit_q);
					else sqrt_q <= 32'(res_q >> 1);
				end
			end
			ST_AT_INIT: begin
				// fold the left half plane into the right by a quarter turn
				if (at_x < 34'sd0) begin
					if (at_y >= 34'sd0) begin
						cx_q <= 46'(at_y);
						cy_q <= -46'(at_x);
						z_q <= HALF_PI_Q30;
					end else begin
						cx_q <= -46'(at_y);
						cy_q <= 46'(at_x);
						z_q <= -HALF_PI_Q30;
					end
				end else begin
					cx_q <= 46'(at_x);
					cy_q <= 46'(at_y);
					z_q <= 34'sd0;
				end
				step_q <= 5'd0;
			end
			ST_AT_NORM: begin
				if (cx_q < NORM_LIMIT && cy_abs < NORM_LIMIT) begin
					cx_q <= cx_q <<< 1;
					cy_q <= cy_q <<< 1;
				end
			end
			ST_AT_ITER: begin
				if (cy_q >= 46'sd0) begin
					cx_q <= cx_q + sh_y;
					cy_q <= cy_q - sh_x;
					z_q <= z_q + $signed({4'd0, atan_q30(step_q)});
				end else begin
					cx_q <= cx_q - sh_y;
					cy_q <= cy_q + sh_x;
					z_q <= z_q - $signed({4'd0, atan_q30(step_q)});
				end
				step_q <= step_q + 5'd1;
			end
			ST_AT_END: begin
				ang_q[which_q] <= z_rnd[33:14];
				which_q <= ~which_q;
			end
			ST_BL_P: p_q <= sat32(66'(st_sel) + 66'(inc_q[which_q]));
			ST_BL_M1: sum_q <= prod_q;
			ST_BL_WB: which_q <= ~which_q;
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_q <= {yaw_q, pitch_q, roll_q, acc_q[2], acc_q[1], acc_q[0]};
				end
			end
			default: ;
		endcase
	end

endmodule
